// ===== hdl/owt_pkg.sv =====
// ----------------------------------------------------------------------------
// owt_pkg
// Shared types, constants and sequence tables for the one-wire read sequencer.
// ----------------------------------------------------------------------------
package owt_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned POS_W    = 4;
    localparam logic [POS_W-1:0] SEQ_LEN = 4'd11;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_IDLE    = 3'd0,
        CFG_RESET_LOW     = 3'd1,
        CFG_RESET_RELEASE = 3'd2,
        CFG_RESET_TAIL    = 3'd3,
        CFG_COMMAND_GAP   = 3'd4,
        CFG_WRITE_SLOT    = 3'd5,
        CFG_READ_SAMPLE   = 3'd6,
        CFG_READ_SLOT     = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_GAP   = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } seq_op_t;

    typedef struct packed {
        logic [TICK_W-1:0]   reset_idle_ticks;
        logic [TICK_W-1:0]   reset_low_ticks;
        logic [TICK_W-1:0]   reset_release_ticks;
        logic [TICK_W-1:0]   reset_tail_ticks;
        logic [TICK_W-1:0]   command_gap_ticks;
        logic [TICK_W-1:0]   write_slot_ticks;
        logic [SAMPLE_W-1:0] read_sample_ticks;
        logic [TICK_W-1:0]   read_slot_ticks;
    } cfg_t;

    typedef struct packed {
        logic        pull_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] raw_reading;
    } step_res_t;

    function automatic seq_op_t seq_op(input logic [POS_W-1:0] pos);
        seq_op_t op;
        case (pos)
            4'd0, 4'd2, 4'd6: op = OP_RESET;
            4'd1, 4'd5, 4'd9: op = OP_GAP;
            4'd3, 4'd4, 4'd7, 4'd8: op = OP_WRITE;
            default: op = OP_READ;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] seq_byte(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            4'd3, 4'd7: b = CMD_SKIP_ROM;
            4'd4:       b = CMD_CONVERT;
            4'd8:       b = CMD_READ_SCRATCH;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/owt_if.sv =====
// ----------------------------------------------------------------------------
// owt_in_if / owt_out_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface owt_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

interface owt_out_if;
    logic        valid;
    logic        ready;
    logic        pull_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] raw_reading;

    modport source (output valid, output pull_low, output busy_res, output done_res,
                    output raw_reading, input ready);
    modport sink   (input valid, input pull_low, input busy_res, input done_res,
                    input raw_reading, output ready);
endinterface

// ===== hdl/one_wire_temperature_read_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_read_sequencer_unit
// One-wire bus master that runs a temperature conversion and scratchpad read.
// ----------------------------------------------------------------------------
// Each tick transaction yields exactly one result transaction. The unit takes
// one tick per clock cycle while the result channel is not stalled; a tick
// passes an input register, the single-step sequencing logic and a result
// register, where its result is presented. Ticks keep flowing while a result
// waits, until both registers are full. The user must write timing registers
// only while no tick is in flight; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module one_wire_temperature_read_sequencer_unit
    import owt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    owt_in_if.sink                req_ch,
    owt_out_if.source             res_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    step_res_t step_res;

    logic      in_valid_reg;
    logic      start_reg;
    logic      line_reg;
    logic      out_valid_reg;
    step_res_t out_reg;
    logic      adv;

    assign adv          = in_valid_reg && (!out_valid_reg || res_ch.ready);
    assign req_ch.ready = !in_valid_reg || adv;

    owt_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .idx   (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    owt_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .start_req  (start_reg),
        .line_level (line_reg),
        .cfg        (cfg),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ch.ready)
            begin
                in_valid_reg <= req_ch.valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.ready && req_ch.valid)
        begin
            start_reg <= req_ch.start_req;
            line_reg  <= req_ch.line_level;
        end
        if (adv)
        begin
            out_reg <= step_res;
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.pull_low    = out_reg.pull_low;
    assign res_ch.busy_res    = out_reg.busy_res;
    assign res_ch.done_res    = out_reg.done_res;
    assign res_ch.raw_reading = out_reg.raw_reading;

endmodule

// ===== hdl/owt_cfg.sv =====
// ----------------------------------------------------------------------------
// owt_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module owt_cfg
    import owt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [CFG_IDX_W-1:0]  idx,
    input  logic [CFG_DATA_W-1:0] data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_idle_ticks    <= 16'd8;
            cfg_reg.reset_low_ticks     <= 16'd80;
            cfg_reg.reset_release_ticks <= 16'd14;
            cfg_reg.reset_tail_ticks    <= 16'd20;
            cfg_reg.command_gap_ticks   <= 16'd80;
            cfg_reg.write_slot_ticks    <= 16'd5;
            cfg_reg.read_sample_ticks   <= 8'd1;
            cfg_reg.read_slot_ticks     <= 16'd4;
        end
        else if (we)
        begin
            unique case (cfg_idx_t'(idx))
                CFG_RESET_IDLE:    cfg_reg.reset_idle_ticks    <= data;
                CFG_RESET_LOW:     cfg_reg.reset_low_ticks     <= data;
                CFG_RESET_RELEASE: cfg_reg.reset_release_ticks <= data;
                CFG_RESET_TAIL:    cfg_reg.reset_tail_ticks    <= data;
                CFG_COMMAND_GAP:   cfg_reg.command_gap_ticks   <= data;
                CFG_WRITE_SLOT:    cfg_reg.write_slot_ticks    <= data;
                CFG_READ_SAMPLE:   cfg_reg.read_sample_ticks   <= data[SAMPLE_W-1:0];
                CFG_READ_SLOT:     cfg_reg.read_slot_ticks     <= data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/owt_fsm.sv =====
// ----------------------------------------------------------------------------
// owt_fsm
// Bus sequencing state machine; advances one tick per enabled cycle.
// ----------------------------------------------------------------------------
module owt_fsm
    import owt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      start_req,
    input  logic      line_level,
    input  cfg_t      cfg,
    output step_res_t res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_RST_IDLE, PH_RST_LOW, PH_RST_REL, PH_RST_TAIL,
        PH_WR_LOW, PH_WR_HOLD, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC, PH_GAP
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic              byte_index_reg, byte_index_next;
    logic [7:0]        shift_byte_reg, shift_byte_next;
    logic [15:0]       reading_reg, reading_next;
    logic [POS_W-1:0]  seq_pos_reg, seq_pos_next;

    logic              busy;
    logic              done;
    logic              drive;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] phase_len;

    function automatic phase_t enter_phase(input logic [POS_W-1:0] pos);
        phase_t p;
        if (pos >= SEQ_LEN)
        begin
            p = PH_IDLE;
        end
        else
        begin
            case (seq_op(pos))
                OP_RESET: p = PH_RST_IDLE;
                OP_GAP:   p = PH_GAP;
                OP_WRITE: p = PH_WR_LOW;
                default:  p = PH_RD_LOW;
            endcase
        end
        return p;
    endfunction

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        byte_index_next = byte_index_reg;
        shift_byte_next = shift_byte_reg;
        reading_next    = reading_reg;
        seq_pos_next    = seq_pos_reg;
        busy            = 1'b0;
        done            = 1'b0;
        drive           = 1'b0;
        tick_inc        = '0;
        phase_len       = '0;

        if (phase_reg == PH_IDLE && start_req)
        begin
            seq_pos_next    = '0;
            phase_next      = enter_phase('0);
            tick_count_next = '0;
            bit_index_next  = '0;
            byte_index_next = 1'b0;
            shift_byte_next = seq_byte('0);
        end

        if (phase_next != PH_IDLE)
        begin
            busy = 1'b1;
            case (phase_next)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b1;
                PH_WR_HOLD:                       drive = ~shift_byte_next[0];
                default:                          drive = 1'b0;
            endcase

            case (phase_next)
                PH_RST_IDLE: phase_len = cfg.reset_idle_ticks;
                PH_RST_LOW:  phase_len = cfg.reset_low_ticks;
                PH_RST_REL:  phase_len = cfg.reset_release_ticks;
                PH_RST_TAIL: phase_len = cfg.reset_tail_ticks;
                PH_WR_HOLD:  phase_len = cfg.write_slot_ticks;
                PH_RD_WAIT:  phase_len = {{(TICK_W-SAMPLE_W){1'b0}}, cfg.read_sample_ticks};
                PH_RD_REC:   phase_len = cfg.read_slot_ticks;
                PH_GAP:      phase_len = cfg.command_gap_ticks;
                default:     phase_len = 16'd1;
            endcase

            tick_inc        = tick_count_next + 16'd1;
            tick_count_next = tick_inc;

            if (tick_inc >= phase_len)
            begin
                tick_count_next = '0;
                case (phase_next)
                    PH_RST_IDLE: phase_next = PH_RST_LOW;
                    PH_RST_LOW:  phase_next = PH_RST_REL;
                    PH_RST_REL:  phase_next = PH_RST_TAIL;
                    PH_WR_LOW:   phase_next = PH_WR_HOLD;
                    PH_RD_LOW:   phase_next = PH_RD_WAIT;
                    PH_RST_TAIL, PH_GAP, PH_WR_HOLD:
                    begin
                        if (phase_next == PH_WR_HOLD)
                        begin
                            shift_byte_next = {1'b0, shift_byte_next[7:1]};
                        end
                        if (phase_next == PH_WR_HOLD && bit_index_next != 3'd7)
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next     = PH_WR_LOW;
                        end
                        else
                        begin
                            seq_pos_next    = seq_pos_next + 4'd1;
                            phase_next      = enter_phase(seq_pos_next);
                            bit_index_next  = '0;
                            byte_index_next = 1'b0;
                            if (seq_pos_next < SEQ_LEN)
                            begin
                                shift_byte_next = seq_byte(seq_pos_next);
                            end
                        end
                    end
                    PH_RD_WAIT:
                    begin
                        shift_byte_next = {line_level, shift_byte_next[7:1]};
                        phase_next      = PH_RD_REC;
                    end
                    PH_RD_REC:
                    begin
                        if (bit_index_next != 3'd7)
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next     = PH_RD_LOW;
                        end
                        else if (!byte_index_next)
                        begin
                            reading_next    = {8'h00, shift_byte_next};
                            byte_index_next = 1'b1;
                            bit_index_next  = '0;
                            shift_byte_next = '0;
                            phase_next      = PH_RD_LOW;
                        end
                        else
                        begin
                            reading_next    = {shift_byte_next, reading_next[7:0]};
                            done            = 1'b1;
                            bit_index_next  = '0;
                            byte_index_next = 1'b0;
                            seq_pos_next    = '0;
                            phase_next      = PH_IDLE;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            byte_index_reg <= 1'b0;
            shift_byte_reg <= '0;
            reading_reg    <= '0;
            seq_pos_reg    <= '0;
        end
        else if (adv)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            byte_index_reg <= byte_index_next;
            shift_byte_reg <= shift_byte_next;
            reading_reg    <= reading_next;
            seq_pos_reg    <= seq_pos_next;
        end
    end

    assign res.pull_low    = drive;
    assign res.busy_res    = busy;
    assign res.done_res    = done;
    assign res.raw_reading = reading_next;

endmodule
